@@ design/mtld_pkg.sv @@
// shared types and constants of the multichannel type-length deframer
`timescale 1ns / 1ps
package mtld_pkg;

    localparam int CHANNELS    = 16;
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef enum logic {
        ACT_DATA  = 1'b0,
        ACT_RESET = 1'b1
    } t_action;

    typedef struct packed {
        logic       action;
        logic [3:0] channel;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [3:0] channel_out;
        logic [7:0] msg_type;
        logic [7:0] msg_length;
        logic [7:0] payload_byte;
        logic       empty_msg;
        logic       last;
    } t_out;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] held_type;
        logic [7:0] held_length;
        logic [7:0] payload_count;
    } t_ctx;

    typedef struct packed {
        logic valid;
        t_out res;
    } t_req;

endpackage

@@ design/mtld_front.sv @@
// front part: per-channel parser contexts and classification of each request
`timescale 1ns / 1ps
module mtld_front
    import mtld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_in,
    output t_req o_req
);

    t_ctx                r_ctx [CHANNELS];
    t_ctx                ctx;
    t_ctx                n_ctx;
    logic [CH_IDX_W-1:0] idx;
    logic                in_range;
    logic [7:0]          cnt;

    assign idx      = CH_IDX_W'(i_in.channel);
    assign in_range = (32'(i_in.channel) < CHANNELS);
    assign ctx      = r_ctx[idx];

    always_comb begin
        n_ctx = ctx;
        o_req = '0;
        cnt   = ctx.payload_count + 8'd1;
        o_req.res.channel_out = i_in.channel;
        o_req.res.msg_type    = ctx.held_type;
        o_req.res.msg_length  = ctx.held_length;
        if (i_in.action == ACT_RESET) begin
            n_ctx = '0;
        end else begin
            unique case (ctx.phase)
                PH_LEN: begin
                    n_ctx.held_length   = i_in.data_byte;
                    n_ctx.payload_count = 8'd0;
                    o_req.res.msg_length = i_in.data_byte;
                    if (i_in.data_byte == 8'd0) begin
                        n_ctx.phase         = PH_TYPE;
                        o_req.valid         = 1'b1;
                        o_req.res.empty_msg = 1'b1;
                        o_req.res.last      = 1'b1;
                    end else begin
                        n_ctx.phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_ctx.payload_count    = cnt;
                    o_req.valid            = 1'b1;
                    o_req.res.payload_byte = i_in.data_byte;
                    o_req.res.last         = (cnt == ctx.held_length);
                    if (cnt == ctx.held_length) begin
                        n_ctx.phase = PH_TYPE;
                    end
                end
                default: begin
                    n_ctx.held_type     = i_in.data_byte;
                    n_ctx.payload_count = 8'd0;
                    n_ctx.phase         = PH_LEN;
                end
            endcase
        end
        if (!(i_accept && in_range)) begin
            o_req.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_ctx[i] <= '0;
            end
        end else if (i_accept && in_range) begin
            r_ctx[idx] <= n_ctx;
        end
    end

endmodule

@@ design/mtld_queue.sv @@
// back part: short result queue that presents the oldest result
`timescale 1ns / 1ps
module mtld_queue
    import mtld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  logic i_pop,
    output t_out o_head,
    output logic o_full,
    output logic o_empty
);

    t_out              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_mem[r_wr] <= i_req.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_req.valid) begin
                r_wr <= (32'(r_wr) == QUEUE_DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (32'(r_rd) == QUEUE_DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
            if (i_req.valid && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_req.valid && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ design/multichannel_type_length_deframer_core.sv @@
// Multichannel type-length deframer. Each request carries a channel number and
// either a data byte or a channel reset; every channel parses its own stream of
// type byte, length byte and payload bytes. One request is taken per clock
// while full is low: the channel's context is read, updated and written back in
// the cycle of acceptance, so the same channel may follow itself with no gap.
// Payload bytes and zero-length messages give one result each, which waits in a
// four-entry queue and shows on the result ports from the next cycle on if the queue was empty. full
// rises only while four results wait unread.
`timescale 1ns / 1ps
module multichannel_type_length_deframer_core
    import mtld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_in,
    output logic empty,
    input  logic pop,
    output t_out o_out
);

    t_req req;
    logic accept;

    assign accept = push && !full;

    mtld_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_req    (req)
    );

    mtld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_pop   (pop),
        .o_head  (o_out),
        .o_full  (full),
        .o_empty (empty)
    );

endmodule

@@ design/mtld_checker.sv @@
// port-level checks of the deframer, bound to the top level
`timescale 1ns / 1ps
module mtld_checker
    import mtld_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input t_in  i_in,
    input logic empty,
    input logic pop,
    input t_out o_out
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("queue not empty after reset");

    a_not_full_and_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(full && empty))
        else $error("full and empty at once");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty && !(push && !full && i_in.action == ACT_DATA) |=> empty)
        else $error("result appeared without a data request");

    a_empty_msg_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out.empty_msg |-> o_out.last && o_out.payload_byte == 8'd0)
        else $error("malformed empty-message result");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_out) && !empty)
        else $error("waiting result changed");

endmodule

bind multichannel_type_length_deframer_core mtld_checker u_mtld_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .i_in    (i_in),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

@@ test/multichannel_type_length_deframer_core_tb.sv @@
// self-checking testbench for the multichannel type-length deframer core
`timescale 1ns / 1ps
module multichannel_type_length_deframer_core_tb;
    import mtld_pkg::*;

    localparam int DIR_ROWS    = 25;
    localparam int RAND_ITEMS  = 45;
    localparam int BIG_CH      = 12;
    localparam int HOLD_LEN    = 40;
    localparam int QUIET_LIMIT = 2000;
    localparam t_out NO_RES    = '0;

    typedef struct packed {
        t_in  req;
        logic fixed;
        t_out res;
    } t_frame_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_in  i_in    = '0;
    logic full;
    logic empty;
    t_out o_out;

    logic drv_fixed = 1'b0;
    t_out drv_res   = '0;

    t_ctx       chan_ctx [CHANNELS];
    t_phase     plan_phase [CHANNELS];
    int         plan_left [CHANNELS];
    t_out       pending_bytes [$];
    t_frame_row script [DIR_ROWS];

    int fail_count     = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    multichannel_type_length_deframer_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_in   (i_in),
        .empty  (empty),
        .pop    (pop),
        .o_out  (o_out)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit deframe_step(input t_in req, output t_out res);
        int         ch;
        logic [7:0] cnt;
        bit         made;
        ch   = int'(req.channel);
        res  = NO_RES;
        made = 1'b0;
        if (ch < CHANNELS) begin
            if (req.action == ACT_RESET) begin
                chan_ctx[ch] = '0;
            end else begin
                case (chan_ctx[ch].phase)
                    PH_LEN: begin
                        chan_ctx[ch].held_length   = req.data_byte;
                        chan_ctx[ch].payload_count = 8'd0;
                        if (req.data_byte == 8'd0) begin
                            chan_ctx[ch].phase = PH_TYPE;
                            res  = {req.channel, chan_ctx[ch].held_type, 8'd0, 8'd0, 1'b1, 1'b1};
                            made = 1'b1;
                        end else begin
                            chan_ctx[ch].phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        cnt = chan_ctx[ch].payload_count + 8'd1;
                        chan_ctx[ch].payload_count = cnt;
                        if (cnt == chan_ctx[ch].held_length) begin
                            chan_ctx[ch].phase = PH_TYPE;
                        end
                        res  = {req.channel, chan_ctx[ch].held_type, chan_ctx[ch].held_length,
                                req.data_byte, 1'b0, cnt == chan_ctx[ch].held_length};
                        made = 1'b1;
                    end
                    default: begin
                        chan_ctx[ch].held_type     = req.data_byte;
                        chan_ctx[ch].payload_count = 8'd0;
                        chan_ctx[ch].phase         = PH_LEN;
                    end
                endcase
            end
        end
        return made;
    endfunction

    // next well-formed data byte for a channel, following its message layout
    function automatic t_in next_req(input int ch, input bit big);
        t_in req;
        int  r;
        req.action    = ACT_DATA;
        req.channel   = 4'(ch);
        req.data_byte = 8'($urandom_range(0, 255));
        case (plan_phase[ch])
            PH_TYPE: begin
                plan_phase[ch] = PH_LEN;
            end
            PH_LEN: begin
                r = int'($urandom_range(0, 99));
                if (big) begin
                    req.data_byte = 8'hFF;
                end else if (r < 20) begin
                    req.data_byte = 8'd0;
                end else if (r < 95) begin
                    req.data_byte = 8'($urandom_range(1, 8));
                end else begin
                    req.data_byte = 8'($urandom_range(9, 40));
                end
                plan_left[ch]  = int'(req.data_byte);
                plan_phase[ch] = (req.data_byte == 8'd0) ? PH_TYPE : PH_DATA;
            end
            default: begin
                plan_left[ch]--;
                if (plan_left[ch] == 0) begin
                    plan_phase[ch] = PH_TYPE;
                end
            end
        endcase
        return req;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic send_req(input t_in req, input logic fixed, input t_out res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in      <= req;
        drv_fixed <= fixed;
        drv_res   <= res;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        t_in req;
        int  ch;
        repeat (count) begin
            if ($urandom_range(0, 9) < 7) begin
                ch = int'($urandom_range(0, 3));
            end else begin
                ch = int'($urandom_range(0, CHANNELS - 1));
            end
            if ($urandom_range(0, 99) < 6) begin
                req.action     = ACT_RESET;
                req.channel    = 4'(ch);
                req.data_byte  = 8'($urandom_range(0, 255));
                plan_phase[ch] = PH_TYPE;
            end else begin
                req = next_req(ch, 1'b0);
            end
            send_req(req, 1'b0, NO_RES);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out want;
        t_out made;
        bit   fired;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (pending_bytes.size() == 0) begin
                    $error("unexpected result on channel %0d", o_out.channel_out);
                    fail_count++;
                end else begin
                    want = pending_bytes.pop_front();
                    check_field("channel_out", int'(want.channel_out), int'(o_out.channel_out));
                    check_field("msg_type", int'(want.msg_type), int'(o_out.msg_type));
                    check_field("msg_length", int'(want.msg_length), int'(o_out.msg_length));
                    check_field("payload_byte", int'(want.payload_byte),
                                int'(o_out.payload_byte));
                    check_field("empty_msg", int'(want.empty_msg), int'(o_out.empty_msg));
                    check_field("last", int'(want.last), int'(o_out.last));
                end
            end
            if (push && !full) begin
                fired = deframe_step(i_in, made);
                if (drv_fixed) begin
                    pending_bytes.push_back(drv_res);
                end else if (fired) begin
                    pending_bytes.push_back(made);
                end
            end
            if ((pop && !empty) || (push && !full)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                pop <= 1'b0;
                hold_cycles--;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin : stimulus
        t_in req;
        for (int c = 0; c < CHANNELS; c++) begin
            chan_ctx[c]   = '0;
            plan_phase[c] = PH_TYPE;
            plan_left[c]  = 0;
        end

        // empty message, one-byte message, reset mid-payload, interleaved channels
        script[0]  = {ACT_DATA,  4'd0,  8'hFF, 1'b0, NO_RES};
        script[1]  = {ACT_DATA,  4'd0,  8'h00, 1'b1, 4'd0, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1};
        script[2]  = {ACT_DATA,  4'd15, 8'h00, 1'b0, NO_RES};
        script[3]  = {ACT_DATA,  4'd15, 8'h01, 1'b0, NO_RES};
        script[4]  = {ACT_DATA,  4'd15, 8'hFF, 1'b1, 4'd15, 8'h00, 8'h01, 8'hFF, 1'b0, 1'b1};
        script[5]  = {ACT_DATA,  4'd5,  8'hA5, 1'b0, NO_RES};
        script[6]  = {ACT_DATA,  4'd5,  8'h03, 1'b0, NO_RES};
        script[7]  = {ACT_DATA,  4'd5,  8'h5A, 1'b0, NO_RES};
        script[8]  = {ACT_RESET, 4'd5,  8'hFF, 1'b0, NO_RES};
        script[9]  = {ACT_DATA,  4'd5,  8'h3C, 1'b0, NO_RES};
        script[10] = {ACT_DATA,  4'd10, 8'hC3, 1'b0, NO_RES};
        script[11] = {ACT_DATA,  4'd5,  8'h02, 1'b0, NO_RES};
        script[12] = {ACT_DATA,  4'd10, 8'h00, 1'b1, 4'd10, 8'hC3, 8'h00, 8'h00, 1'b1, 1'b1};
        script[13] = {ACT_DATA,  4'd5,  8'h00, 1'b0, NO_RES};
        script[14] = {ACT_DATA,  4'd5,  8'h80, 1'b0, NO_RES};
        script[15] = {ACT_DATA,  4'd3,  8'h77, 1'b0, NO_RES};
        script[16] = {ACT_RESET, 4'd3,  8'h00, 1'b0, NO_RES};
        script[17] = {ACT_DATA,  4'd3,  8'h01, 1'b0, NO_RES};
        script[18] = {ACT_DATA,  4'd3,  8'hFF, 1'b0, NO_RES};
        script[19] = {ACT_DATA,  4'd3,  8'h11, 1'b0, NO_RES};
        script[20] = {ACT_RESET, 4'd3,  8'hAA, 1'b0, NO_RES};
        script[21] = {ACT_RESET, 4'd7,  8'h55, 1'b0, NO_RES};
        script[22] = {ACT_DATA,  4'd7,  8'h00, 1'b0, NO_RES};
        script[23] = {ACT_DATA,  4'd7,  8'h01, 1'b0, NO_RES};
        script[24] = {ACT_DATA,  4'd7,  8'hFF, 1'b0, NO_RES};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_req(script[i].req, script[i].fixed, script[i].res);
        end

        // no idling; receiver holds off at the start while a full-length message streams in
        hold_cycles = HOLD_LEN;
        req.action    = ACT_RESET;
        req.channel   = 4'(BIG_CH);
        req.data_byte = 8'($urandom_range(0, 255));
        plan_phase[BIG_CH] = PH_TYPE;
        send_req(req, 1'b0, NO_RES);
        repeat (257) begin
            req = next_req(BIG_CH, 1'b1);
            send_req(req, 1'b0, NO_RES);
        end
        send_random(RAND_ITEMS);

        send_idle_pct  = 83;
        recv_stall_pct = 0;
        send_random(RAND_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 83;
        send_random(RAND_ITEMS);

        send_idle_pct  = 15;
        recv_stall_pct = 15;
        send_random(RAND_ITEMS);

        push      <= 1'b0;
        drv_fixed <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending_bytes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/mtld_pkg.sv
design/mtld_front.sv
design/mtld_queue.sv
design/multichannel_type_length_deframer_core.sv
design/mtld_checker.sv
test/multichannel_type_length_deframer_core_tb.sv
